>>> rtl/tced_pkg.sv
package tced_pkg;

	localparam int FLOOR_W = 4;

	typedef enum logic [1:0] {
		FN_HALL  = 2'd0,
		FN_CABIN = 2'd1,
		FN_REACH = 2'd2,
		FN_TICK  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_CMD    = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_IGNORE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CMD_FREE = 2'd0,
		CMD_UP   = 2'd1,
		CMD_DOWN = 2'd2,
		CMD_STOP = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		HEAD_STAND = 2'd0,
		HEAD_UP    = 2'd1,
		HEAD_DOWN  = 2'd2
	} head_t;

	typedef enum logic [2:0] {
		MODE_FREE     = 3'd0,
		MODE_HALL     = 3'd1,
		MODE_CABIN    = 3'd2,
		MODE_REACHED  = 3'd3,
		MODE_MANAGING = 3'd4
	} mode_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch input beat
		logic clr_scan;  // restart per-car scan
		logic scan_step; // examine one floor
		logic next_car;  // advance car index for scan
		logic commit;    // apply the item and build result(s)
		logic emit;      // present result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic scan_done;  // last floor of current car examined
		logic car_last;   // current car is the last car
	} dp_sts_t;

endpackage

>>> rtl/tced_if.sv
interface tced_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [3:0] floor;
	logic       call_up;
	logic       car;
	modport source (output valid, func, floor, call_up, car, input ready);
	modport sink (input valid, func, floor, call_up, car, output ready);
endinterface

interface tced_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic       car_index;
	logic [3:0] floor_index;
	logic [1:0] command;
	logic       hall_lamp_up;
	logic       all_free;
	logic       last;
	modport source (output valid, kind, car_index, floor_index, command, hall_lamp_up,
		all_free, last, input ready);
	modport sink (input valid, kind, car_index, floor_index, command, hall_lamp_up,
		all_free, last, output ready);
endinterface

>>> rtl/tced_ctrl.sv
module tced_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              res_last,
	input  tced_pkg::dp_sts_t sts,
	output tced_pkg::dp_cmd_t cmd
);
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_COMMIT = 5'b00100,
		ST_OUT    = 5'b01000,
		ST_NEXT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// sequencing: scan floors per car, then commit, then deliver beat(s)
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					if (sts.car_last) begin
						state_d = ST_COMMIT;
					end else begin
						cmd.next_car = 1'b1;
					end
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) begin
					cmd.emit = 1'b1;
					state_d = res_last ? ST_IDLE : ST_NEXT;
				end
			end
			ST_NEXT: begin
				state_d = ST_OUT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

>>> rtl/tced_dp.sv
module tced_dp #(
	parameter int FLOORS      = 16,
	parameter int CARS        = 2,
	parameter int START_INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tced_pkg::dp_cmd_t cmd,
	output tced_pkg::dp_sts_t sts,
	input  logic [1:0]        in_func,
	input  logic [3:0]        in_floor,
	input  logic              in_call_up,
	input  logic              in_car,
	output logic [1:0]        kind,
	output logic              car_index,
	output logic [3:0]        floor_index,
	output logic [1:0]        command,
	output logic              hall_lamp_up,
	output logic              all_free,
	output logic              last
);
	localparam int FW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
	localparam int CW = (CARS > 1) ? $clog2(CARS) : 1;
	localparam int NW = $clog2(FLOORS + 2);
	localparam int START = (START_INDEX > FLOORS - 1) ? FLOORS - 1 : START_INDEX;
	localparam int DW = FW + 2;

	// car state
	logic [FW-1:0]     pos_q  [CARS];
	logic [1:0]        head_q [CARS];
	logic [FLOORS-1:0] pend_q [CARS];
	tced_pkg::mode_t   mode_q;

	// latched item
	logic [1:0] func_q;
	logic [3:0] floor_q;
	logic       up_q;
	logic       car_q;

	// scan state, per car results
	logic [CW-1:0] sc_q;
	logic [FW-1:0] sf_q;
	logic [NW-1:0] cnt_q  [CARS];
	logic          tgt_v_q [CARS];
	logic [FW-1:0] tgt_q  [CARS];
	logic [DW-1:0] bestd_q [CARS];
	logic          fwd_v_q [CARS];
	logic [FW-1:0] fwd_q  [CARS];
	logic          bwd_v_q [CARS];
	logic [FW-1:0] bwd_q  [CARS];
	logic          ahead_q [CARS];

	// results
	logic [1:0]    r_kind_q  [CARS];
	logic [CW-1:0] r_car_q   [CARS];
	logic [3:0]    r_floor_q [CARS];
	logic [1:0]    r_cmd_q   [CARS];
	logic          r_lamp_q  [CARS];
	logic          r_free_q;
	logic [CW-1:0] nres_q;
	logic [CW-1:0] ridx_q;

	logic is_tick;
	assign is_tick = (func_q == tced_pkg::FN_TICK);

	assign sts.is_tick   = is_tick;
	assign sts.scan_done = (sf_q == FW'(FLOORS - 1));
	assign sts.car_last  = (sc_q == CW'(CARS - 1));

	// current scan element
	logic          cur_pend;
	logic [FW-1:0] cpos;
	logic [1:0]    chead;
	logic [DW-1:0] fdiff;
	assign cpos     = pos_q[sc_q];
	assign chead    = head_q[sc_q];
	assign cur_pend = pend_q[sc_q][sf_q];
	assign fdiff    = (cpos > sf_q) ? DW'(cpos - sf_q) : DW'(sf_q - cpos);

	// floor out of range on the narrow input
	logic floor_bad;
	logic car_bad;
	assign floor_bad = ({1'b0, floor_q} >= 5'(FLOORS > 31 ? 31 : FLOORS)) &&
		(FLOORS < 16);
	assign car_bad   = ({1'b0, car_q} >= 2'(CARS > 2 ? 2 : CARS));

	// scan target: nearest for standing cars, else forward hit then backward hit
	logic          sel_v [CARS];
	logic [FW-1:0] sel_t [CARS];
	always_comb begin
		for (int c = 0; c < CARS; c++) begin
			if (head_q[c] == tced_pkg::HEAD_STAND) begin
				sel_v[c] = tgt_v_q[c];
				sel_t[c] = tgt_q[c];
			end else begin
				sel_v[c] = fwd_v_q[c] | bwd_v_q[c];
				sel_t[c] = fwd_v_q[c] ? fwd_q[c] : bwd_q[c];
			end
		end
	end

	// hall call choice (combinational over cars, independent elements)
	logic [CW-1:0] h_chosen;
	always_comb begin
		logic [DW-1:0] mind;
		logic [NW-1:0] minn;
		logic [DW-1:0] hop;
		logic [1:0]    need;
		logic          found;
		h_chosen = '0;
		mind = DW'(FLOORS + 1);
		minn = NW'(FLOORS);
		found = 1'b0;
		for (int c = 0; c < CARS; c++) begin
			hop = ({2'b0, floor_q[FW-1:0]} > {2'b0, pos_q[c]}) ?
				DW'(floor_q[FW-1:0] - pos_q[c]) : DW'(pos_q[c] - floor_q[FW-1:0]);
			need = (floor_q[FW-1:0] == pos_q[c]) ? tced_pkg::HEAD_STAND :
				((floor_q[FW-1:0] < pos_q[c]) ? tced_pkg::HEAD_DOWN : tced_pkg::HEAD_UP);
			if (head_q[c] == tced_pkg::HEAD_STAND || (need == head_q[c] &&
				(up_q ? tced_pkg::HEAD_UP : tced_pkg::HEAD_DOWN) == head_q[c])) begin
				if (hop < mind) begin
					mind = hop;
					h_chosen = CW'(c);
					found = 1'b1;
				end
			end
		end
		if (!found) begin
			for (int c = 0; c < CARS; c++) begin
				if (cnt_q[c] < minn) begin
					minn = cnt_q[c];
					h_chosen = CW'(c);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CARS; c++) begin
				pos_q[c]  <= FW'(START);
				head_q[c] <= tced_pkg::HEAD_STAND;
				pend_q[c] <= '0;
			end
			mode_q <= tced_pkg::MODE_FREE;
		end else if (cmd.commit) begin
			if (is_tick) begin
				logic nf;
				nf = 1'b1;
				for (int c = 0; c < CARS; c++) begin
					if (!sel_v[c]) begin
						head_q[c] <= tced_pkg::HEAD_STAND;
					end else if (sel_t[c] > pos_q[c]) begin
						head_q[c] <= tced_pkg::HEAD_UP;
						pos_q[c]  <= pos_q[c] + 1'b1;
						nf = 1'b0;
					end else if (sel_t[c] < pos_q[c]) begin
						head_q[c] <= tced_pkg::HEAD_DOWN;
						pos_q[c]  <= pos_q[c] - 1'b1;
						nf = 1'b0;
					end else begin
						nf = 1'b0;
						if (head_q[c] == tced_pkg::HEAD_STAND) begin
							head_q[c] <= tced_pkg::HEAD_STAND;
						end else if (!ahead_q[c]) begin
							head_q[c] <= (head_q[c] == tced_pkg::HEAD_UP) ?
								tced_pkg::HEAD_DOWN : tced_pkg::HEAD_UP;
						end
					end
				end
				mode_q <= nf ? tced_pkg::MODE_FREE : tced_pkg::MODE_MANAGING;
			end else if (floor_bad) begin
				mode_q <= mode_q;
			end else if (func_q == tced_pkg::FN_HALL) begin
				mode_q <= tced_pkg::MODE_HALL;
				pend_q[h_chosen][floor_q[FW-1:0]] <= 1'b1;
			end else if (car_bad) begin
				mode_q <= mode_q;
			end else if (func_q == tced_pkg::FN_CABIN) begin
				mode_q <= tced_pkg::MODE_CABIN;
				pend_q[CW'(car_q)][floor_q[FW-1:0]] <= 1'b1;
			end else if (mode_q == tced_pkg::MODE_CABIN || mode_q == tced_pkg::MODE_HALL ||
				mode_q == tced_pkg::MODE_MANAGING) begin
				mode_q <= tced_pkg::MODE_REACHED;
				pend_q[CW'(car_q)][floor_q[FW-1:0]] <= 1'b0;
			end
		end
	end

	// item latch, floor scan and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q   <= '0;
			sf_q   <= '0;
			ridx_q <= '0;
			nres_q <= '0;
		end else begin
			if (cmd.load) begin
				func_q  <= in_func;
				floor_q <= in_floor;
				up_q    <= in_call_up;
				car_q   <= in_car;
				sc_q    <= '0;
				sf_q    <= '0;
				ridx_q  <= '0;
			end
			if (cmd.scan_step) begin
				logic fv;
				logic bv;
				logic av;
				fv = (sf_q == '0) ? 1'b0 : fwd_v_q[sc_q];
				bv = (sf_q == '0) ? 1'b0 : bwd_v_q[sc_q];
				av = (sf_q == '0) ? 1'b0 : ahead_q[sc_q];
				// one floor per cycle: count, nearest, forward and backward hits
				if (sf_q == '0) begin
					cnt_q[sc_q]   <= NW'(cur_pend);
					tgt_v_q[sc_q] <= cur_pend;
					tgt_q[sc_q]   <= '0;
					bestd_q[sc_q] <= cur_pend ? fdiff : DW'(FLOORS);
				end else begin
					cnt_q[sc_q] <= cnt_q[sc_q] + NW'(cur_pend);
					if (cur_pend && fdiff < bestd_q[sc_q]) begin
						bestd_q[sc_q] <= fdiff;
						tgt_q[sc_q]   <= sf_q;
						tgt_v_q[sc_q] <= 1'b1;
					end
				end
				if (cur_pend) begin
					if (chead == tced_pkg::HEAD_UP) begin
						// first pending at or above, last pending below
						if (sf_q >= cpos && !fv) begin
							fv = 1'b1;
							fwd_q[sc_q] <= sf_q;
						end
						if (sf_q < cpos) begin
							bv = 1'b1;
							bwd_q[sc_q] <= sf_q;
						end
						if (sf_q > cpos) begin
							av = 1'b1;
						end
					end else if (chead == tced_pkg::HEAD_DOWN) begin
						// last pending at or below, first pending above
						if (sf_q <= cpos) begin
							fv = 1'b1;
							fwd_q[sc_q] <= sf_q;
						end
						if (sf_q > cpos && !bv) begin
							bv = 1'b1;
							bwd_q[sc_q] <= sf_q;
						end
						if (sf_q < cpos) begin
							av = 1'b1;
						end
					end
				end
				fwd_v_q[sc_q] <= fv;
				bwd_v_q[sc_q] <= bv;
				ahead_q[sc_q] <= av;
				sf_q <= (sf_q == FW'(FLOORS - 1)) ? '0 : sf_q + 1'b1;
			end
			if (cmd.next_car) begin
				sc_q <= sc_q + 1'b1;
			end
			if (cmd.commit) begin
				logic nf;
				logic [1:0] cm;
				logic [FW-1:0] np;
				logic [1:0] rk;
				logic [CW-1:0] rc;
				logic [3:0] rf;
				logic rl;
				nf = 1'b1;
				for (int c = 0; c < CARS; c++) begin
					rk = tced_pkg::KIND_IGNORE;
					rc = '0;
					rf = '0;
					cm = tced_pkg::CMD_FREE;
					rl = 1'b0;
					np = pos_q[c];
					if (is_tick) begin
						if (!sel_v[c]) begin
							cm = tced_pkg::CMD_FREE;
						end else if (sel_t[c] > pos_q[c]) begin
							cm = tced_pkg::CMD_UP;
							np = pos_q[c] + 1'b1;
							nf = 1'b0;
						end else if (sel_t[c] < pos_q[c]) begin
							cm = tced_pkg::CMD_DOWN;
							np = pos_q[c] - 1'b1;
							nf = 1'b0;
						end else begin
							cm = tced_pkg::CMD_STOP;
							nf = 1'b0;
						end
						rk = tced_pkg::KIND_CMD;
						rc = CW'(c);
						rf = 4'(np);
					end else if (c == 0) begin
						if (floor_bad) begin
							rk = tced_pkg::KIND_IGNORE;
						end else if (func_q == tced_pkg::FN_HALL) begin
							rk = tced_pkg::KIND_ACCEPT;
							rc = h_chosen;
							rf = floor_q;
							rl = up_q;
						end else if (car_bad) begin
							rk = tced_pkg::KIND_IGNORE;
						end else if (func_q == tced_pkg::FN_CABIN) begin
							rk = tced_pkg::KIND_ACCEPT;
							rc = CW'(car_q);
							rf = floor_q;
						end else if (mode_q == tced_pkg::MODE_CABIN ||
							mode_q == tced_pkg::MODE_HALL ||
							mode_q == tced_pkg::MODE_MANAGING) begin
							rk = tced_pkg::KIND_CLEAR;
							rc = CW'(car_q);
							rf = floor_q;
							rl = (head_q[CW'(car_q)] == tced_pkg::HEAD_UP);
						end
					end
					r_kind_q[c]  <= rk;
					r_car_q[c]   <= rc;
					r_floor_q[c] <= rf;
					r_cmd_q[c]   <= cm;
					r_lamp_q[c]  <= rl;
				end
				r_free_q <= is_tick & nf;
				nres_q   <= is_tick ? CW'(CARS - 1) : '0;
			end
			if (cmd.emit) begin
				ridx_q <= ridx_q + 1'b1;
			end
		end
	end

	// output mux
	logic          o_last;
	assign o_last = (ridx_q == nres_q);
	assign kind         = r_kind_q[ridx_q];
	assign car_index    = 1'(r_car_q[ridx_q]);
	assign floor_index  = r_floor_q[ridx_q];
	assign command      = r_cmd_q[ridx_q];
	assign hall_lamp_up = r_lamp_q[ridx_q];
	assign all_free     = o_last & r_free_q & is_tick;
	assign last         = o_last;
endmodule

>>> rtl/two_car_elevator_dispatch.sv
// channel | dir | beat contents
// in      | in  | func, floor, call_up, car
// out     | out | kind, car_index, floor_index, command, hall_lamp_up, all_free, last
//
// each item: accept, a scan of every floor of every car (one floor of one car per
// cycle), commit, then the first beat; each further result passes through ST_NEXT
// before its beat; a tick gives one result per car, any other item a single result
// reset (arst_n low) puts every car at the start floor, standing, none pending
// a stalled output beat holds until taken; no new item enters meanwhile
module two_car_elevator_dispatch #(
	parameter int FLOORS      = 16,
	parameter int CARS        = 2,
	parameter int START_INDEX = 0
) (
	input logic       clk,
	input logic       arst_n,
	tced_in_if.sink   in_ch,
	tced_out_if.source out_ch
);
	tced_pkg::dp_cmd_t cmd;
	tced_pkg::dp_sts_t sts;

	tced_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.res_last  (out_ch.last),
		.sts       (sts),
		.cmd       (cmd)
	);

	tced_dp #(
		.FLOORS      (FLOORS),
		.CARS        (CARS),
		.START_INDEX (START_INDEX)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_func      (in_ch.func),
		.in_floor     (in_ch.floor),
		.in_call_up   (in_ch.call_up),
		.in_car       (in_ch.car),
		.kind         (out_ch.kind),
		.car_index    (out_ch.car_index),
		.floor_index  (out_ch.floor_index),
		.command      (out_ch.command),
		.hall_lamp_up (out_ch.hall_lamp_up),
		.all_free     (out_ch.all_free),
		.last         (out_ch.last)
	);
endmodule

>>> rtl/tced_checker.sv
module tced_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input logic out_all_free
);
	// no new item while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input open during output");

	// all_free only on the last beat
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_all_free |-> out_last) else $error("all_free on non-last beat");

	// accepted item closes input next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("input stayed open");

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("beat dropped");
endmodule

bind two_car_elevator_dispatch tced_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_last     (out_ch.last),
	.out_all_free (out_ch.all_free)
);
